### design/sorted_priority_queue_core_defines.svh
// Assertion macros used by the sorted priority queue datapath.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/spq_pkg.sv
// Package for the sorted priority queue: transaction types, status codes and
// the controller/datapath command and status structs. Depends on nothing.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int SPQ_DEPTH = 16;
    localparam int VAL_W     = 16;
    localparam int ID_W      = 16;
    localparam int OCC_W     = 5;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_CONSUME = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_RETURNED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_POP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic             command;
        logic [VAL_W-1:0] item_value;
        logic [ID_W-1:0]  item_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] out_value;
        logic [ID_W-1:0]  out_id;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [ID_W-1:0]  id;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;     // capture the accepted item, cursor = count
        logic    rd_head;   // read the head entry
        logic    rd_prev;   // read the entry just above the cursor
        logic    wr_new;    // write the new entry at the cursor
        logic    wr_shift;  // move the read entry down to the cursor, cursor--
        logic    push;      // count++
        logic    pop;       // head++, count--
        logic    out_load;  // load the output register
        t_status out_code;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic idx_zero;
        logic rd_gt;
        logic out_free;
    } t_dp_sts;

endpackage

### design/spq_ctrl.sv
// Controller of the sorted priority queue: sequences insert and consume
// transactions over the datapath. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_command,
    input  t_dp_sts  i_sts,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state  r_state, n_state;
    t_status r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_INSERTED;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.out_code = r_code;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    if (i_command == CMD_INSERT) begin
                        if (i_sts.full) begin
                            n_code  = ST_FULL;
                            n_state = S_FIN;
                        end else begin
                            n_code  = ST_INSERTED;
                            n_state = S_INS_RD;
                        end
                    end else begin
                        if (i_sts.empty) begin
                            n_code  = ST_EMPTY;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.rd_head = 1'b1;
                            n_code  = ST_RETURNED;
                            n_state = S_POP;
                        end
                    end
                end
            end
            S_INS_RD: begin
                if (i_sts.idx_zero) begin
                    o_cmd.wr_new = 1'b1;
                    o_cmd.push   = 1'b1;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                if (i_sts.rd_gt) begin
                    o_cmd.wr_new = 1'b1;
                    o_cmd.push   = 1'b1;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.wr_shift = 1'b1;
                    n_state        = S_INS_RD;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/spq_datapath.sv
// Datapath of the sorted priority queue: circular entry memory, head pointer,
// count, insert cursor and output register. Depends on spq_pkg and the
// assertion macros header.
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_defines.svh"

module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  logic      i_out_ready,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          mem [DEPTH];
    t_entry          r_rd_data;
    t_in_item        r_item;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   r_head;
    logic [CW-1:0]   r_idx;
    logic            r_out_valid;
    t_out_item       r_out;

    logic [CW-1:0]   idx_prev;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    t_entry          wr_data;
    logic            rd_en;
    logic            wr_en;

    // Logical slot (0 = head) to physical memory address.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [AW-1:0] slot);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, slot};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign idx_prev = r_idx - CW'(1);
    assign rd_en    = i_cmd.rd_head | i_cmd.rd_prev;
    assign rd_addr  = i_cmd.rd_head ? r_head : phys(r_head, idx_prev[AW-1:0]);
    assign wr_en    = i_cmd.wr_new | i_cmd.wr_shift;
    assign wr_addr  = phys(r_head, r_idx[AW-1:0]);
    assign wr_data  = i_cmd.wr_new ? t_entry'{value: r_item.item_value,
                                              id: r_item.item_id}
                                   : r_rd_data;

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CW'(DEPTH));
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.rd_gt    = (r_rd_data.value > r_item.item_value);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // Entry memory, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_data;
        end
        if (i_cmd.out_load) begin
            r_out.status    <= i_cmd.out_code;
            r_out.occupancy <= OCC_W'(r_count);
            if (i_cmd.out_code == ST_RETURNED) begin
                r_out.out_value <= r_rd_data.value;
                r_out.out_id    <= r_rd_data.id;
            end else begin
                r_out.out_value <= '0;
                r_out.out_id    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_head      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_idx <= r_count;
            end else if (i_cmd.wr_shift) begin
                r_idx <= idx_prev;
            end
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
                if (r_head == AW'(DEPTH - 1)) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_head + AW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "count exceeds depth")
    `SPQ_ASSERT_NOW(a_push_not_full, i_cmd.push, !o_sts.full, "push into a full queue")
    `SPQ_ASSERT_NOW(a_pop_not_empty, i_cmd.pop, !o_sts.empty, "pop from an empty queue")
    `SPQ_ASSERT_NOW(a_out_no_overwrite, i_cmd.out_load, o_sts.out_free,
        "output register overwritten while held")
    `SPQ_ASSERT_NEXT(a_push_counts, i_cmd.push, r_count == $past(r_count) + CW'(1),
        "insert did not raise the count")

endmodule

### design/sorted_priority_queue_core.sv
// Sorted priority queue: a circular-buffer memory of up to DEPTH entries kept
// in descending value order, with a controller and a datapath. Depends on
// spq_pkg, spq_ctrl and spq_datapath.
//
// Each input transaction is an insert (command 0) or a consume (command 1),
// and each yields exactly one output transaction carrying a status, the
// returned value and tag (zero unless an entry was returned) and the
// occupancy after the step. An insert places the new entry ahead of every
// entry whose value is lower than or equal to its own, so equal values come
// out newest first; an insert into a full queue is rejected with the full
// status, and a consume of an empty queue reports empty. The block works on
// one transaction at a time. A consume reads the head entry when it is
// accepted, advances the head pointer and then loads its result; a rejected
// insert or an empty consume loads its result directly. An insert walks a
// cursor from the tail toward the head: because the entry memory has a
// registered read, each entry above the insertion point is read (S_INS_RD),
// then compared and written back one slot lower (S_INS_CHK). The search ends
// when the cursor reaches the head or a compare finds a larger entry, and the
// new entry is written at the cursor. The last step of a transaction, loading
// the output register, waits until that register is taken. Consumes advance
// a head pointer and never move entries. A finished result waits in the
// output register; the next transaction may be accepted meanwhile, and its
// result is held back until the register is taken. The entry memory has no
// reset and no clearing pass; only slots below the count are ever read.
// DEPTH may range from 2 to 256; occupancy reports the low 5 bits of the
// count.
`timescale 1ns / 1ps

module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Command and status bundles between the controller and the datapath.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // The controller decides the sequence of memory reads, writes and
    // pointer updates for each transaction.
    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_data.command),
        .i_sts      (dp_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the entries, the count, the head pointer and the
    // output register.
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### bench/tb.sv
// Self-checking testbench for sorted_priority_queue_core: a directed table, then
// random insert/consume traffic with idle bursts on both channels, checked
// against a behavioral sorted queue. Depends on spq_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int          RAND_ITEMS   = 1200;
    localparam int          QUIET_ITEMS  = 150;
    localparam int          SEG_ITEMS    = 60;
    localparam int          DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          MAX_REPORTS  = 10;

    // One row of the directed table. When has_typed is set, the expected
    // status and occupancy are written out here and the value and tag are zero.
    typedef struct {
        logic            cmd;
        logic [VAL_W-1:0] value;
        logic [ID_W-1:0]  id;
        bit              has_typed;
        t_status         status;
        logic [OCC_W-1:0] occupancy;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    // Behavioral copy of the queue contents, head at slot 0.
    t_entry      held_entries[SPQ_DEPTH];
    int          held_count;
    t_out_item   expected_results[$];
    t_dir_row    directed_rows[$];
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned stall_pct    = 0;
    int unsigned ready_left   = 0;
    int unsigned gap_pct      = 0;

    sorted_priority_queue_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Applies one transaction to the behavioral queue and returns its result.
    function automatic t_out_item queue_step(input t_in_item item);
        t_out_item res;
        int        pos;
        res = '0;
        if (item.command == CMD_INSERT) begin
            if (held_count >= SPQ_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // A new entry goes ahead of every entry with a lower or equal
                // value, so ties come out newest first.
                pos = 0;
                while (pos < held_count && held_entries[pos].value > item.item_value)
                    pos++;
                for (int k = held_count; k > pos; k--)
                    held_entries[k] = held_entries[k-1];
                held_entries[pos].value = item.item_value;
                held_entries[pos].id    = item.item_id;
                held_count++;
                res.status = ST_INSERTED;
            end
        end else if (held_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.status    = ST_RETURNED;
            res.out_value = held_entries[0].value;
            res.out_id    = held_entries[0].id;
            for (int k = 1; k < held_count; k++)
                held_entries[k-1] = held_entries[k];
            held_count--;
        end
        res.occupancy = OCC_W'(held_count);
        return res;
    endfunction

    task automatic add_row(input logic cmd, input logic [VAL_W-1:0] value,
                           input logic [ID_W-1:0] id, input bit has_typed,
                           input t_status status, input logic [OCC_W-1:0] occupancy);
        t_dir_row row;
        row.cmd       = cmd;
        row.value     = value;
        row.id        = id;
        row.has_typed = has_typed;
        row.status    = status;
        row.occupancy = occupancy;
        directed_rows.push_back(row);
    endtask

    // Presents one transaction, waits for it to be taken, records what it
    // should produce, and then may leave the input idle for a burst.
    task automatic send_item(input t_in_item item, input bit has_typed,
                             input t_out_item typed_result);
        t_out_item predicted;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = queue_step(item);
        expected_results.push_back(has_typed ? typed_result : predicted);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Output side: ready is re-drawn low or high whenever the burst counter
    // ready_left runs out; with no stall requested it simply stays high.
    always @(posedge i_clk) begin
        if (stall_pct == 0) begin
            i_out_ready <= 1'b1;
            ready_left  <= 0;
        end else if (ready_left > 1) begin
            ready_left <= ready_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(1, 100) > stall_pct);
            ready_left  <= $urandom_range(1, 16);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d value %h id %h occ %0d",
                             o_out_data.status, o_out_data.out_value,
                             o_out_data.out_id, o_out_data.occupancy);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.status !== want.status
                        || o_out_data.out_value !== want.out_value
                        || o_out_data.out_id !== want.out_id
                        || o_out_data.occupancy !== want.occupancy) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result mismatch: expected status %0d value %h id %h ",
                                  "occ %0d, got status %0d value %h id %h occ %0d"},
                                 want.status, want.out_value, want.out_id,
                                 want.occupancy, o_out_data.status,
                                 o_out_data.out_value, o_out_data.out_id,
                                 o_out_data.occupancy);
                end
            end
        end
    end

    initial begin : stimulus
        t_in_item  item;
        t_out_item typed_result;
        int        ins_pct;
        int        value_style;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        held_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty consume, extreme values and tags, a tie with
        // the head, a tie at the tail, filling up, a rejected insert when full.
        add_row(CMD_CONSUME, 16'h0000, 16'h0000, 1'b1, ST_EMPTY, 5'd0);
        add_row(CMD_INSERT, 16'hFFFF, 16'hFFFF, 1'b1, ST_INSERTED, 5'd1);
        add_row(CMD_INSERT, 16'h0000, 16'h0000, 1'b1, ST_INSERTED, 5'd2);
        add_row(CMD_INSERT, 16'hFFFF, 16'h1234, 1'b0, ST_INSERTED, 5'd0);
        add_row(CMD_CONSUME, 16'h0000, 16'h0000, 1'b0, ST_INSERTED, 5'd0);
        add_row(CMD_INSERT, 16'h8000, 16'hA5A5, 1'b0, ST_INSERTED, 5'd0);
        add_row(CMD_INSERT, 16'h7FFF, 16'h5A5A, 1'b0, ST_INSERTED, 5'd0);
        add_row(CMD_INSERT, 16'h0000, 16'h0001, 1'b0, ST_INSERTED, 5'd0);
        for (int i = 0; i < 11; i++)
            add_row(CMD_INSERT, 16'(i * 5000), 16'(16'hC000 + i), 1'b0, ST_INSERTED, 5'd0);
        add_row(CMD_INSERT, 16'h4321, 16'hBEEF, 1'b1, ST_FULL, 5'd16);
        // The value and tag bits of a consume carry no meaning.
        add_row(CMD_CONSUME, 16'hFFFF, 16'hFFFF, 1'b0, ST_INSERTED, 5'd0);

        gap_pct   = 25;
        stall_pct <= 25;
        foreach (directed_rows[r]) begin
            item.command        = directed_rows[r].cmd;
            item.item_value     = directed_rows[r].value;
            item.item_id        = directed_rows[r].id;
            typed_result        = '0;
            typed_result.status = directed_rows[r].status;
            typed_result.occupancy = directed_rows[r].occupancy;
            send_item(item, directed_rows[r].has_typed, typed_result);
        end

        // Random traffic in segments. Each segment leans toward filling,
        // draining or holding the queue level, and picks a value style that
        // either spreads values or crowds them together to force ties.
        ins_pct     = 50;
        value_style = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % SEG_ITEMS == 0) begin
                case ($urandom_range(0, 2))
                    0: ins_pct = 85;
                    1: ins_pct = 15;
                    default: ins_pct = 50;
                endcase
                value_style = $urandom_range(0, 2);
                // Idling is only re-chosen before the closing stretch.
                if (n < RAND_ITEMS - QUIET_ITEMS) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            gap_pct   = 0;
                            stall_pct <= 0;
                        end
                        1: begin
                            gap_pct   = 15;
                            stall_pct <= 15;
                        end
                        default: begin
                            gap_pct   = 50;
                            stall_pct <= 50;
                        end
                    endcase
                end
            end
            // No idling at all in the closing stretch.
            if (n == RAND_ITEMS - QUIET_ITEMS) begin
                gap_pct   = 0;
                stall_pct <= 0;
            end
            item.command = ($urandom_range(1, 100) <= ins_pct) ? CMD_INSERT : CMD_CONSUME;
            case (value_style)
                0: item.item_value = VAL_W'($urandom_range(0, 65535));
                1: item.item_value = VAL_W'($urandom_range(0, 7));
                default: begin
                    case ($urandom_range(0, 5))
                        0: item.item_value = 16'h0000;
                        1: item.item_value = 16'h0001;
                        2: item.item_value = 16'h7FFF;
                        3: item.item_value = 16'h8000;
                        4: item.item_value = 16'hFFFE;
                        default: item.item_value = 16'hFFFF;
                    endcase
                end
            endcase
            item.item_id = ID_W'($urandom_range(0, 65535));
            send_item(item, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sorted_priority_queue_core.f
+incdir+design
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/sorted_priority_queue_core.sv
bench/tb.sv
